/* hdl/kt_pkg.sv */
// Shared types and codes for the keyed table.
package kt_pkg;

    localparam logic [1:0] REQ_ADD  = 2'd0;
    localparam logic [1:0] REQ_FIND = 2'd1;
    localparam logic [1:0] REQ_DEL  = 2'd2;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_NOT_FOUND = 2'd1,
        STS_DUPLICATE = 2'd2,
        STS_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_MV_RD,
        S_MV_WR
    } t_state;

    typedef struct packed {
        t_status     status;
        logic [31:0] found_value;
        logic [5:0]  slot;
        logic [6:0]  count;
    } t_result;

endpackage

/* hdl/kt_mem.sv */
// Entry store: key and value pairs, one write port, one registered read port.
module kt_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 64
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/kt_ctrl.sv */
// Request sequencer: linear scan with one shared key comparator, add and delete write-back.
module kt_ctrl #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int CW    = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [1:0]          i_req_type,
    input  logic signed [31:0]  i_key,
    input  logic [31:0]         i_value,
    input  logic [6:0]          i_capacity,
    output logic                o_busy,
    output logic                o_mem_rd_en,
    output logic [AW-1:0]       o_mem_rd_addr,
    input  logic [63:0]         i_mem_rd_data,
    output logic                o_mem_wr_en,
    output logic [AW-1:0]       o_mem_wr_addr,
    output logic [63:0]         o_mem_wr_data,
    output logic                o_done,
    output kt_pkg::t_result     o_res
);

    localparam int LW = (CW > 7) ? CW : 7;

    kt_pkg::t_state  r_state, n_state;
    logic [1:0]      r_kind, n_kind;
    logic [31:0]     r_key, n_key;
    logic [31:0]     r_value, n_value;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_idx, n_idx;
    logic            r_pend, n_pend;
    logic [AW-1:0]   r_cidx, n_cidx;
    logic            r_done, n_done;
    kt_pkg::t_result r_res, n_res;

    logic            full;
    logic            match;
    logic            last_hit;
    logic            scan_miss;
    logic [CW-1:0]   last;

    assign full      = (LW'(r_count) >= LW'(i_capacity)) || (int'(r_count) >= DEPTH);
    assign match     = r_pend && (i_mem_rd_data[63:32] == r_key);
    assign last_hit  = r_pend && ((CW'(r_cidx) + CW'(1)) == r_count);
    assign scan_miss = r_pend && !match && last_hit;
    assign last      = r_count - CW'(1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            kt_pkg::S_IDLE: begin
                if (i_start) begin
                    case (i_req_type)
                        kt_pkg::REQ_ADD: begin
                            if (!full && r_count != '0) begin
                                n_state = kt_pkg::S_SCAN;
                            end
                        end
                        kt_pkg::REQ_FIND, kt_pkg::REQ_DEL: begin
                            if (r_count != '0) begin
                                n_state = kt_pkg::S_SCAN;
                            end
                        end
                        default: n_state = kt_pkg::S_IDLE;
                    endcase
                end
            end
            kt_pkg::S_SCAN: begin
                if (match) begin
                    if (r_kind == kt_pkg::REQ_DEL && !last_hit) begin
                        n_state = kt_pkg::S_MV_RD;
                    end else begin
                        n_state = kt_pkg::S_IDLE;
                    end
                end else if (scan_miss) begin
                    n_state = kt_pkg::S_IDLE;
                end
            end
            kt_pkg::S_MV_RD: n_state = kt_pkg::S_MV_WR;
            kt_pkg::S_MV_WR: n_state = kt_pkg::S_IDLE;
            default:         n_state = kt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_kind        = r_kind;
        n_key         = r_key;
        n_value       = r_value;
        n_count       = r_count;
        n_idx         = r_idx;
        n_pend        = r_pend;
        n_cidx        = r_cidx;
        n_done        = 1'b0;
        n_res         = r_res;
        o_mem_rd_en   = 1'b0;
        o_mem_rd_addr = r_idx[AW-1:0];
        o_mem_wr_en   = 1'b0;
        o_mem_wr_addr = r_count[AW-1:0];
        o_mem_wr_data = {r_key, r_value};
        case (r_state)
            kt_pkg::S_IDLE: begin
                if (i_start) begin
                    n_kind  = i_req_type;
                    n_key   = i_key;
                    n_value = i_value;
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    case (i_req_type)
                        kt_pkg::REQ_ADD: begin
                            if (full) begin
                                n_done = 1'b1;
                                n_res  = '{kt_pkg::STS_FULL, 32'd0, 6'd0, 7'(r_count)};
                            end else if (r_count == '0) begin
                                o_mem_wr_en   = 1'b1;
                                o_mem_wr_addr = '0;
                                o_mem_wr_data = {i_key, i_value};
                                n_count       = CW'(1);
                                n_done        = 1'b1;
                                n_res         = '{kt_pkg::STS_OK, 32'd0, 6'd0, 7'd1};
                            end
                        end
                        kt_pkg::REQ_FIND, kt_pkg::REQ_DEL: begin
                            if (r_count == '0) begin
                                n_done = 1'b1;
                                n_res  = '{kt_pkg::STS_NOT_FOUND, 32'd0, 6'd0, 7'(r_count)};
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                            n_res  = '{kt_pkg::STS_NOT_FOUND, 32'd0, 6'd0, 7'(r_count)};
                        end
                    endcase
                end
            end
            kt_pkg::S_SCAN: begin
                if (match) begin
                    case (r_kind)
                        kt_pkg::REQ_FIND: begin
                            n_done = 1'b1;
                            n_res  = '{kt_pkg::STS_OK, i_mem_rd_data[31:0], 6'(r_cidx),
                                       7'(r_count)};
                        end
                        kt_pkg::REQ_DEL: begin
                            if (last_hit) begin
                                n_count = last;
                                n_done  = 1'b1;
                                n_res   = '{kt_pkg::STS_OK, 32'd0, 6'(r_cidx), 7'(last)};
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                            n_res  = '{kt_pkg::STS_DUPLICATE, 32'd0, 6'd0, 7'(r_count)};
                        end
                    endcase
                end else if (scan_miss) begin
                    n_done = 1'b1;
                    if (r_kind == kt_pkg::REQ_ADD) begin
                        o_mem_wr_en = 1'b1;
                        n_count     = r_count + CW'(1);
                        n_res       = '{kt_pkg::STS_OK, 32'd0, 6'(r_count),
                                        7'(r_count + CW'(1))};
                    end else begin
                        n_res = '{kt_pkg::STS_NOT_FOUND, 32'd0, 6'd0, 7'(r_count)};
                    end
                end else if (r_idx < r_count) begin
                    o_mem_rd_en = 1'b1;
                    n_pend      = 1'b1;
                    n_cidx      = r_idx[AW-1:0];
                    n_idx       = r_idx + CW'(1);
                end else begin
                    n_pend = 1'b0;
                end
            end
            kt_pkg::S_MV_RD: begin
                o_mem_rd_en   = 1'b1;
                o_mem_rd_addr = last[AW-1:0];
            end
            kt_pkg::S_MV_WR: begin
                // last entry fills the freed slot
                o_mem_wr_en   = 1'b1;
                o_mem_wr_addr = r_cidx;
                o_mem_wr_data = i_mem_rd_data;
                n_count       = last;
                n_done        = 1'b1;
                n_res         = '{kt_pkg::STS_OK, 32'd0, 6'(r_cidx), 7'(last)};
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kt_pkg::S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_key   <= n_key;
        r_value <= n_value;
        r_idx   <= n_idx;
        r_cidx  <= n_cidx;
        r_res   <= n_res;
    end

    assign o_busy = (r_state != kt_pkg::S_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= DEPTH)
        else $error("live count above depth");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == kt_pkg::S_IDLE))
        else $error("result beat while still busy");

    a_cmp_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kt_pkg::S_SCAN && r_pend) |-> (CW'(r_cidx) < r_count))
        else $error("compare on a slot beyond the live entries");

    a_move_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kt_pkg::S_MV_WR) |-> (CW'(r_cidx) < last))
        else $error("delete move targets the last slot");

endmodule

/* hdl/keyed_table_find_insert_delete.sv */
// Top level of the keyed table: capacity register, sequencer and entry store.
//
//  channel   direction  handshake               payload
//  request   in         start && !busy          i_req_type, i_key, i_value
//  result    out        o_done (one cycle)      o_status, o_found_value, o_slot, o_count
//  config    in         i_cfg_we                i_cfg_wdata (capacity)
//
// The scan reads one stored key per cycle through the single memory read port.
// A hit ends the scan at the matching slot; a miss ends it once the last live entry is compared.
// A delete that moves the last entry adds a read state and a write-back state (S_MV_RD, S_MV_WR).
// An add to a full table, unused request kinds and an empty table answer straight from idle, with no scan.
// Reset empties the table and sets capacity to 64; the receiver cannot stall results.
module keyed_table_find_insert_delete #(
    parameter int DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_req_type,
    input  logic signed [31:0] i_key,
    input  logic [31:0]        i_value,
    input  logic               i_cfg_we,
    input  logic [6:0]         i_cfg_wdata,
    output logic               o_done,
    output logic [1:0]         o_status,
    output logic [31:0]        o_found_value,
    output logic [5:0]         o_slot,
    output logic [6:0]         o_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [6:0]      r_capacity;
    logic            mem_rd_en;
    logic [AW-1:0]   mem_rd_addr;
    logic [63:0]     mem_rd_data;
    logic            mem_wr_en;
    logic [AW-1:0]   mem_wr_addr;
    logic [63:0]     mem_wr_data;
    kt_pkg::t_result res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= 7'd64;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    kt_ctrl #(
        .DEPTH(DEPTH),
        .AW   (AW),
        .CW   (CW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_req_type   (i_req_type),
        .i_key        (i_key),
        .i_value      (i_value),
        .i_capacity   (r_capacity),
        .o_busy       (busy),
        .o_mem_rd_en  (mem_rd_en),
        .o_mem_rd_addr(mem_rd_addr),
        .i_mem_rd_data(mem_rd_data),
        .o_mem_wr_en  (mem_wr_en),
        .o_mem_wr_addr(mem_wr_addr),
        .o_mem_wr_data(mem_wr_data),
        .o_done       (o_done),
        .o_res        (res)
    );

    kt_mem #(
        .DEPTH(DEPTH),
        .AW   (AW),
        .DW   (64)
    ) u_mem (
        .i_clk    (i_clk),
        .i_wr_en  (mem_wr_en),
        .i_wr_addr(mem_wr_addr),
        .i_wr_data(mem_wr_data),
        .i_rd_en  (mem_rd_en),
        .i_rd_addr(mem_rd_addr),
        .o_rd_data(mem_rd_data)
    );

    assign o_status      = res.status;
    assign o_found_value = res.found_value;
    assign o_slot        = res.slot;
    assign o_count       = res.count;

endmodule
